[rtl/core/vmtx_pkg.sv]
package vmtx_pkg;

  localparam int unsigned RING_WORDS_MAX   = 8192;
  localparam int unsigned OUT_IDX_W        = 13;
  // trailer holds the old write index in bits 47:32
  localparam int unsigned TRL_IDX_W        = 16;
  localparam int unsigned CFG_W            = 14;
  localparam int unsigned NEED_W           = 17;
  localparam int unsigned MIN_RING_WORDS   = 512;
  localparam int unsigned RING_WORDS_RESET = 8192;
  // header length in 8-byte units, also the data offset in header word 0
  localparam int unsigned DATA_OFFSET_QW   = 2;
  // header words plus trailer word
  localparam int unsigned OVERHEAD_WORDS   = 3;
  localparam int unsigned TRAILER_SHIFT    = 32;
  localparam int unsigned JOB_DEPTH        = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_HOST  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_UNEXPECTED = 2'd2
  } status_e;

  typedef enum logic {
    RK_STATUS = 1'b0,
    RK_WRITE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] packet_type;
    logic [18:0] payload_bytes;
    logic        response_required;
    logic [63:0] xact_id;
    logic [63:0] data_word;
    logic [12:0] host_read_index;
    logic        host_interrupt_mask;
  } vmtx_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [12:0] ring_offset;
    logic [63:0] ring_word;
    logic [1:0]  status;
    logic        commit;
    logic [12:0] committed_write_index;
    logic        signal_host;
    logic        last;
  } vmtx_out_t;

  // one queued job: a status report, or one or two ring words with an optional trailer
  typedef struct packed {
    logic                 is_write;
    status_e              status;
    logic                 two;
    logic                 tr;
    logic                 sig;
    logic [63:0]          w0;
    logic [63:0]          w1;
    logic [OUT_IDX_W-1:0] off0;
    logic [OUT_IDX_W-1:0] off1;
    logic [OUT_IDX_W-1:0] off_tr;
    logic [OUT_IDX_W-1:0] new_wi;
    logic [TRL_IDX_W-1:0] old_wi;
  } vmtx_job_t;

endpackage

[rtl/core/vmtx_front.sv]
module vmtx_front import vmtx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vmtx_in_t         in_data_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             push_o,
  output vmtx_job_t        job_o,
  input  logic             full_i
);

  localparam int unsigned IdxW = $clog2(RING_WORDS_MAX);
  localparam int unsigned LW   = $clog2(RING_WORDS_MAX + 1);
  localparam int unsigned CmpW = (LW > CFG_W) ? LW : CFG_W;

  function automatic logic [IdxW-1:0] adv(input logic [IdxW-1:0] pos,
                                          input logic [LW-1:0] len);
    logic [LW-1:0] n;
    n = LW'(pos) + LW'(1);
    return (n >= len) ? '0 : IdxW'(n);
  endfunction

  logic [CFG_W-1:0] ring_words_q, ring_words_d;
  logic [IdxW-1:0]  write_index_q, write_index_d;
  logic [IdxW-1:0]  read_index_q, read_index_d;
  logic             mask_q, mask_d;
  logic [IdxW-1:0]  cursor_q, cursor_d;
  logic             in_packet_q, in_packet_d;
  logic             dropping_q, dropping_d;
  logic [15:0]      words_left_q, words_left_d;
  logic [2:0]       tail_bytes_q, tail_bytes_d;

  logic [CmpW-1:0]   rw_ext;
  logic [LW-1:0]     len_c;
  logic [LW-1:0]     free_c;
  logic [NEED_W-1:0] pw_c;
  logic [NEED_W-1:0] need_c;
  logic              reject_c;
  logic [NEED_W-1:0] rem_c;
  logic [NEED_W-1:0] lsh_c;
  logic [63:0]       keep_c;
  logic [63:0]       data_c;
  logic [IdxW-1:0]   nw1, nw2, nw3, nc1, nc2;
  logic              sig_c;
  logic [15:0]       wl_dec;
  logic              accept;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;

  // clamp the programmed length
  always_comb begin
    rw_ext = CmpW'(ring_words_q);
    if (rw_ext < CmpW'(MIN_RING_WORDS)) begin
      len_c = LW'(MIN_RING_WORDS);
    end else if (rw_ext > CmpW'(RING_WORDS_MAX)) begin
      len_c = LW'(RING_WORDS_MAX);
    end else begin
      len_c = LW'(rw_ext);
    end
  end

  always_comb begin
    if (write_index_q >= read_index_q) begin
      free_c = len_c - (LW'(write_index_q) - LW'(read_index_q));
    end else begin
      free_c = LW'(read_index_q) - LW'(write_index_q);
    end
    pw_c     = NEED_W'((20'(in_data_i.payload_bytes) + 20'd7) >> 3);
    need_c   = pw_c + NEED_W'(OVERHEAD_WORDS);
    reject_c = pw_c[NEED_W-1] || (need_c >= NEED_W'(free_c));
  end

  // host read index modulo length: quotient stays below 16, four restoring steps
  always_comb begin
    rem_c = NEED_W'(in_data_i.host_read_index);
    lsh_c = '0;
    for (int k = 3; k >= 0; k--) begin
      lsh_c = NEED_W'(len_c) << k;
      if (rem_c >= lsh_c) begin
        rem_c = rem_c - lsh_c;
      end
    end
  end

  // zero bytes past the payload end on the last word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep_c[8*i +: 8] = (3'(i) < tail_bytes_q) ? 8'hff : 8'h00;
    end
    if (words_left_q == 16'd1 && tail_bytes_q != 3'd0) begin
      data_c = in_data_i.data_word & keep_c;
    end else begin
      data_c = in_data_i.data_word;
    end
  end

  assign nw1    = adv(write_index_q, len_c);
  assign nw2    = adv(nw1, len_c);
  assign nw3    = adv(nw2, len_c);
  assign nc1    = adv(cursor_q, len_c);
  assign nc2    = adv(nc1, len_c);
  assign sig_c  = !mask_q && (write_index_q == read_index_q);
  assign wl_dec = words_left_q - 16'd1;

  always_comb begin
    ring_words_d  = ring_words_q;
    write_index_d = write_index_q;
    read_index_d  = read_index_q;
    mask_d        = mask_q;
    cursor_d      = cursor_q;
    in_packet_d   = in_packet_q;
    dropping_d    = dropping_q;
    words_left_d  = words_left_q;
    tail_bytes_d  = tail_bytes_q;
    push_o        = 1'b0;
    job_o         = '0;
    job_o.status  = ST_OK;
    job_o.old_wi  = TRL_IDX_W'(write_index_q);

    if (cfg_valid_i) begin
      ring_words_d  = cfg_data_i;
      write_index_d = '0;
      read_index_d  = '0;
      cursor_d      = '0;
      in_packet_d   = 1'b0;
      dropping_d    = 1'b0;
      words_left_d  = '0;
      tail_bytes_d  = '0;
    end else if (accept) begin
      unique case (op_e'(in_data_i.operation))
        OP_HOST: begin
          read_index_d = IdxW'(rem_c);
          mask_d       = in_data_i.host_interrupt_mask;
        end
        OP_START: begin
          push_o = 1'b1;
          if (in_packet_q || dropping_q) begin
            job_o.status = ST_UNEXPECTED;
          end else if (reject_c) begin
            job_o.status = ST_NO_SPACE;
            if (pw_c != '0) begin
              dropping_d   = 1'b1;
              words_left_d = pw_c[NEED_W-1] ? 16'hffff : pw_c[15:0];
            end
          end else begin
            job_o.is_write = 1'b1;
            job_o.two      = 1'b1;
            job_o.w0       = {15'd0, in_data_i.response_required,
                              16'(pw_c + NEED_W'(DATA_OFFSET_QW)),
                              16'(DATA_OFFSET_QW), in_data_i.packet_type};
            job_o.w1       = in_data_i.xact_id;
            job_o.off0     = OUT_IDX_W'(write_index_q);
            job_o.off1     = OUT_IDX_W'(nw1);
            in_packet_d    = 1'b1;
            cursor_d       = nw2;
            words_left_d   = pw_c[15:0];
            tail_bytes_d   = in_data_i.payload_bytes[2:0];
            if (pw_c == '0) begin
              // empty payload: trailer right behind the header
              job_o.tr      = 1'b1;
              job_o.off_tr  = OUT_IDX_W'(nw2);
              job_o.new_wi  = OUT_IDX_W'(nw3);
              job_o.sig     = sig_c;
              write_index_d = nw3;
              cursor_d      = nw3;
              in_packet_d   = 1'b0;
            end
          end
        end
        OP_DATA: begin
          if (dropping_q) begin
            words_left_d = wl_dec;
            if (wl_dec == 16'd0) begin
              dropping_d = 1'b0;
            end
          end else if (in_packet_q) begin
            push_o         = 1'b1;
            job_o.is_write = 1'b1;
            job_o.w0       = data_c;
            job_o.off0     = OUT_IDX_W'(cursor_q);
            cursor_d       = nc1;
            words_left_d   = wl_dec;
            if (wl_dec == 16'd0) begin
              job_o.tr      = 1'b1;
              job_o.off_tr  = OUT_IDX_W'(nc1);
              job_o.new_wi  = OUT_IDX_W'(nc2);
              job_o.sig     = sig_c;
              write_index_d = nc2;
              cursor_d      = nc2;
              in_packet_d   = 1'b0;
            end
          end else begin
            push_o       = 1'b1;
            job_o.status = ST_UNEXPECTED;
          end
        end
        default: begin
          push_o       = 1'b1;
          job_o.status = ST_UNEXPECTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_words_q  <= CFG_W'(RING_WORDS_RESET);
      write_index_q <= '0;
      read_index_q  <= '0;
      mask_q        <= 1'b0;
      cursor_q      <= '0;
      in_packet_q   <= 1'b0;
      dropping_q    <= 1'b0;
      words_left_q  <= '0;
      tail_bytes_q  <= '0;
    end else begin
      ring_words_q  <= ring_words_d;
      write_index_q <= write_index_d;
      read_index_q  <= read_index_d;
      mask_q        <= mask_d;
      cursor_q      <= cursor_d;
      in_packet_q   <= in_packet_d;
      dropping_q    <= dropping_d;
      words_left_q  <= words_left_d;
      tail_bytes_q  <= tail_bytes_d;
    end
  end

endmodule

[rtl/core/vmtx_queue.sv]
module vmtx_queue import vmtx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  vmtx_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output vmtx_job_t job_o
);

  localparam int unsigned PtrW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(JOB_DEPTH + 1);

  vmtx_job_t       mem_q [JOB_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(JOB_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(JOB_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(JOB_DEPTH))
    else $error("job queue count out of range");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("job queue count missed a request");

endmodule

[rtl/core/vmtx_back.sv]
module vmtx_back import vmtx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  vmtx_job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vmtx_out_t out_data_o
);

  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  vmtx_out_t  out_q, out_d;
  vmtx_out_t  res_c;
  logic       load;
  logic       tr_slot, d1_slot, final_slot;

  assign load = !out_valid_q || out_ready_i;

  // slot order: word 0, word 1 when present, then trailer when present
  always_comb begin
    tr_slot    = job_i.tr && (step_q == (job_i.two ? 2'd2 : 2'd1));
    d1_slot    = job_i.two && (step_q == 2'd1);
    final_slot = tr_slot || (!job_i.tr && (step_q == (job_i.two ? 2'd1 : 2'd0)));

    res_c                       = '0;
    res_c.committed_write_index = OUT_IDX_W'(job_i.old_wi);
    res_c.status                = ST_OK;
    if (!job_i.is_write) begin
      res_c.result_kind = RK_STATUS;
      res_c.status      = job_i.status;
      res_c.last        = 1'b1;
    end else if (tr_slot) begin
      res_c.result_kind           = RK_WRITE;
      res_c.ring_offset           = job_i.off_tr;
      res_c.ring_word             = 64'(job_i.old_wi) << TRAILER_SHIFT;
      res_c.commit                = 1'b1;
      res_c.committed_write_index = job_i.new_wi;
      res_c.signal_host           = job_i.sig;
      res_c.last                  = 1'b1;
    end else begin
      res_c.result_kind = RK_WRITE;
      res_c.ring_offset = d1_slot ? job_i.off1 : job_i.off0;
      res_c.ring_word   = d1_slot ? job_i.w1 : job_i.w0;
      res_c.last        = final_slot;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    step_d      = step_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d = res_c;
        if (res_c.last) begin
          pop_o  = 1'b1;
          step_d = '0;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_commit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.commit) |-> (out_q.last && out_q.result_kind == RK_WRITE))
    else $error("commit not on the final ring write");

  a_signal_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.signal_host) |-> out_q.commit)
    else $error("host signal without commit");

  a_step_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == 2'd0))
    else $error("slot counter not cleared after job");

endmodule

[rtl/core/vmbus_tx_ring_packet_writer_core.sv]
// Transmit ring packet writer. A start request checks ring space and, when the packet
// fits, gives two header writes (plus trailer and commit for an empty payload); each
// payload word request gives one ring write, the last one also the trailer write that
// commits the new write index. A new request is taken every cycle while the two-entry
// job queue has room; the result side sends one result per cycle from its output
// register while the output is ready, so a start request that fits gives two or three
// results and the final payload word two. Results pass the job queue, then the output
// register. Host update requests and dropped payload words give no result. The length
// register is always ready and must only be written while idle; writing it clears the
// ring indices and any packet in progress but keeps the host interrupt mask.
module vmbus_tx_ring_packet_writer_core import vmtx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vmtx_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vmtx_out_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  vmtx_job_t job_in;
  vmtx_job_t job_out;

  vmtx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  vmtx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .job_o  (job_out)
  );

  vmtx_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
